FILE: hdl/assert_macros.svh
// Assertion macros shared by the converter's modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// trigger implies the consequence on the following edge
`define ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/yuyv_pkg.sv
// Shared types and constants of the YUYV to RGB converter
`default_nettype none
package yuyv_pkg;

   localparam int MAX_LINE_PIXELS = 4096;
   localparam int MAX_LINES       = 4096;
   localparam int CFG_WIDTH       = 13;
   localparam int CNT_WIDTH       = 12;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = QUEUE_PTR_WIDTH + 1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_HEIGHT = 2'd1;

   typedef struct packed {
      logic [7:0] luma_first;
      logic [7:0] chroma_blue;
      logic [7:0] luma_second;
      logic [7:0] chroma_red;
   } req_word_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last_of_pair;
      logic       end_of_line;
      logic       end_of_frame;
   } rsp_word_type;

   typedef struct packed {
      req_word_type pixels;
      logic         end_of_line;
      logic         end_of_frame;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

FILE: hdl/yuyv_to_rgb_converter.sv
// Top level of the YUYV 4:2:2 to RGB888 converter
//
//   channel  | ports            | word
//   ---------+------------------+--------------------------------------------
//   input    | req_valid/ready  | req_data: one YUYV macropixel
//   result   | rsp_valid/ready  | rsp_data: one RGB888 pixel with markers
//   control  | csr_valid/ready  | csr_index, csr_wdata: frame width / height
//
// Two result words per macropixel; the back end converts one pixel a cycle
// while the result side is ready and the queue holds a word.
// Input reaches the first pixel through the queue and then the output register.
// A two-word queue decouples the input from the conversion; input stalls only
// when it is full. Synchronous reset clears counters, queue, output valid and
// pair phase and sets the frame to 640 by 480.
`default_nettype none
module yuyv_to_rgb_converter (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output      logic                                  req_ready,
   input  wire yuyv_pkg::req_word_type                req_data,
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_ready,
   output      yuyv_pkg::rsp_word_type                rsp_data,
   input  wire logic                                  csr_valid,
   output      logic                                  csr_ready,
   input  wire logic [yuyv_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [yuyv_pkg::CFG_WIDTH-1:0]        csr_wdata
);

   yuyv_pkg::queue_status_type queue_status;
   yuyv_pkg::queue_entry_type  push_entry;
   yuyv_pkg::queue_entry_type  head;
   logic                       push;
   logic                       pop;

   yuyv_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .queue_status (queue_status),
      .push         (push),
      .push_entry   (push_entry)
   );

   yuyv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (queue_status)
   );

   yuyv_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

endmodule
`default_nettype wire

FILE: hdl/yuyv_front.sv
// Front end: register file, line and frame counters, marker classification
`default_nettype none
`include "assert_macros.svh"
module yuyv_front (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      req_valid,
   output      logic                                      req_ready,
   input  wire yuyv_pkg::req_word_type                    req_data,
   input  wire logic                                      csr_valid,
   output      logic                                      csr_ready,
   input  wire logic [yuyv_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  wire logic [yuyv_pkg::CFG_WIDTH-1:0]            csr_wdata,
   input  wire yuyv_pkg::queue_status_type                queue_status,
   output      logic                                      push,
   output      yuyv_pkg::queue_entry_type                 push_entry
);

   logic [yuyv_pkg::CFG_WIDTH-1:0] width_ff, width_in;
   logic [yuyv_pkg::CFG_WIDTH-1:0] height_ff, height_in;
   logic [yuyv_pkg::CNT_WIDTH-1:0] column_ff, column_in;
   logic [yuyv_pkg::CNT_WIDTH-1:0] row_ff, row_in;
   logic [yuyv_pkg::CFG_WIDTH-1:0] width_lim;
   logic [yuyv_pkg::CFG_WIDTH-1:0] height_lim;
   logic [yuyv_pkg::CFG_WIDTH:0]   pixels_done;
   logic [yuyv_pkg::CFG_WIDTH-1:0] rows_done;
   logic                           eol;
   logic                           eof;

   assign csr_ready = 1'b1;
   assign req_ready = !queue_status.full;
   assign push      = req_valid && req_ready;

   always_comb begin
      width_lim = width_ff;
      if (width_ff > yuyv_pkg::CFG_WIDTH'(yuyv_pkg::MAX_LINE_PIXELS)) begin
         width_lim = yuyv_pkg::CFG_WIDTH'(yuyv_pkg::MAX_LINE_PIXELS);
      end else if (width_ff < yuyv_pkg::CFG_WIDTH'(2)) begin
         width_lim = yuyv_pkg::CFG_WIDTH'(2);
      end
      height_lim = height_ff;
      if (height_ff > yuyv_pkg::CFG_WIDTH'(yuyv_pkg::MAX_LINES)) begin
         height_lim = yuyv_pkg::CFG_WIDTH'(yuyv_pkg::MAX_LINES);
      end else if (height_ff == '0) begin
         height_lim = yuyv_pkg::CFG_WIDTH'(1);
      end
   end

   assign pixels_done = {({1'b0, column_ff} + yuyv_pkg::CFG_WIDTH'(1)), 1'b0};
   assign rows_done   = {1'b0, row_ff} + yuyv_pkg::CFG_WIDTH'(1);
   assign eol = pixels_done >= {1'b0, width_lim};
   assign eof = eol && (rows_done >= height_lim);

   always_comb begin
      push_entry.pixels       = req_data;
      push_entry.end_of_line  = eol;
      push_entry.end_of_frame = eof;
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      column_in = column_ff;
      row_in    = row_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            yuyv_pkg::CSR_FRAME_WIDTH:  width_in  = csr_wdata;
            yuyv_pkg::CSR_FRAME_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
      if (push) begin
         if (eol) begin
            column_in = '0;
            row_in    = eof ? '0 : row_ff + yuyv_pkg::CNT_WIDTH'(1);
         end else begin
            column_in = column_ff + yuyv_pkg::CNT_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= yuyv_pkg::CFG_WIDTH'(640);
         height_ff <= yuyv_pkg::CFG_WIDTH'(480);
         column_ff <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

   `ASSERT_NEXT(a_eol_clears_column, push && eol, column_ff == '0, "column not cleared at line end")
   `ASSERT_ALWAYS(a_eof_needs_eol, !eof || eol, "frame end without line end")

endmodule
`default_nettype wire

FILE: hdl/yuyv_queue.sv
// Short queue of classified words between front and back end
`default_nettype none
`include "assert_macros.svh"
module yuyv_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire yuyv_pkg::queue_entry_type   push_entry,
   input  wire logic                        pop,
   output      yuyv_pkg::queue_entry_type   head,
   output      yuyv_pkg::queue_status_type  status
);

   yuyv_pkg::queue_entry_type              entry_ff [yuyv_pkg::QUEUE_DEPTH];
   logic [yuyv_pkg::QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [yuyv_pkg::QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [yuyv_pkg::QUEUE_CNT_WIDTH-1:0]   count_ff, count_in;

   assign status.full  = count_ff == yuyv_pkg::QUEUE_CNT_WIDTH'(yuyv_pkg::QUEUE_DEPTH);
   assign status.empty = count_ff == '0;
   assign head         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == yuyv_pkg::QUEUE_PTR_WIDTH'(yuyv_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + yuyv_pkg::QUEUE_PTR_WIDTH'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == yuyv_pkg::QUEUE_PTR_WIDTH'(yuyv_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + yuyv_pkg::QUEUE_PTR_WIDTH'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + yuyv_pkg::QUEUE_CNT_WIDTH'(1);
      end else if (pop && !push) begin
         count_in = count_ff - yuyv_pkg::QUEUE_CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `ASSERT_ALWAYS(a_queue_bounds, !(push && status.full && !pop) && !(pop && status.empty),
                  "queue overflow or underflow")

endmodule
`default_nettype wire

FILE: hdl/yuyv_back.sv
// Back end: colour-converts a pixel per unstalled cycle into output register
`default_nettype none
`include "assert_macros.svh"
module yuyv_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire yuyv_pkg::queue_entry_type   head,
   input  wire yuyv_pkg::queue_status_type  queue_status,
   output      logic                        pop,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   output      yuyv_pkg::rsp_word_type      rsp_data
);

   function automatic logic [7:0] clamp_channel(input logic signed [19:0] acc);
      logic [7:0] res;
      if (acc[19]) begin
         res = 8'd0;
      end else if (|acc[18:16]) begin
         res = 8'd255;
      end else begin
         res = acc[15:8];
      end
      return res;
   endfunction

   logic                    rsp_valid_ff, rsp_valid_in;
   yuyv_pkg::rsp_word_type  rsp_data_ff, rsp_data_in;
   logic                    phase_ff, phase_in;
   logic                    load;
   logic                    fire;
   logic [7:0]              luma;
   logic signed [19:0]      ys;
   logic signed [19:0]      cb;
   logic signed [19:0]      cr;
   logic signed [19:0]      acc_r;
   logic signed [19:0]      acc_g;
   logic signed [19:0]      acc_b;

   assign load = !rsp_valid_ff || rsp_ready;
   assign fire = load && !queue_status.empty;
   assign pop  = fire && phase_ff;

   assign luma  = phase_ff ? head.pixels.luma_second : head.pixels.luma_first;
   assign ys    = $signed({4'b0000, luma, 8'h00});
   assign cb    = 20'(signed'({~head.pixels.chroma_blue[7], head.pixels.chroma_blue[6:0]}));
   assign cr    = 20'(signed'({~head.pixels.chroma_red[7], head.pixels.chroma_red[6:0]}));
   assign acc_r = ys + 20'sd359 * cr;
   assign acc_g = ys - 20'sd88 * cb - 20'sd183 * cr;
   assign acc_b = ys + 20'sd454 * cb;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      phase_in     = phase_ff;
      if (load) begin
         rsp_valid_in = fire;
      end
      if (fire) begin
         rsp_data_in.red          = clamp_channel(acc_r);
         rsp_data_in.green        = clamp_channel(acc_g);
         rsp_data_in.blue         = clamp_channel(acc_b);
         rsp_data_in.last_of_pair = phase_ff;
         rsp_data_in.end_of_line  = phase_ff && head.end_of_line;
         rsp_data_in.end_of_frame = phase_ff && head.end_of_frame;
         phase_in                 = !phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_ALWAYS(a_first_no_marks, !rsp_valid_ff || rsp_data_ff.last_of_pair ||
                  (!rsp_data_ff.end_of_line && !rsp_data_ff.end_of_frame),
                  "marker on first pixel of pair")
   `ASSERT_NEXT(a_pair_order, fire, rsp_data_ff.last_of_pair != phase_ff,
                "pixel order within pair broken")

endmodule
`default_nettype wire

FILE: bench/tb_yuyv_to_rgb_converter.sv
// Self-checking bench: YUYV macropixels in, predicted RGB pixels and line/frame markers checked
`timescale 1ns / 1ps
module tb_yuyv_to_rgb_converter;
   import yuyv_pkg::*;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_3 = 2'd3;
   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;
   localparam int PHASES       = 12;
   localparam int CORNERS      = 14;
   localparam int HOLD_CYCLES  = 120;
   localparam int DRAIN_CYCLES = 8;
   localparam int LIMIT_NS     = 1_000_000;

   class rgb_predictor;
      rsp_word_type pixel_queue[$];
      logic [CFG_WIDTH-1:0] width_reg;
      logic [CFG_WIDTH-1:0] height_reg;
      logic [CNT_WIDTH-1:0] column_count;
      logic [CNT_WIDTH-1:0] row_count;
      int errors;
      int words_in;
      int pixels_checked;

      function new();
         width_reg = CFG_WIDTH'(RESET_WIDTH);
         height_reg = CFG_WIDTH'(RESET_HEIGHT);
         column_count = '0;
         row_count = '0;
         errors = 0;
         words_in = 0;
         pixels_checked = 0;
      endfunction

      function int pending();
         return pixel_queue.size();
      endfunction

      function void note_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] val);
         case (idx)
            CSR_FRAME_WIDTH: width_reg = val;
            CSR_FRAME_HEIGHT: height_reg = val;
            default: ;
         endcase
      endfunction

      function logic [7:0] clamp8(int acc);
         if (acc < 0) return 8'd0;
         acc = acc / 256;
         return (acc > 255) ? 8'd255 : acc[7:0];
      endfunction

      function rsp_word_type convert(int y, int cb, int cr);
         rsp_word_type px;
         int ys;
         ys = y * 256;
         px.red = clamp8(ys + 359 * cr);
         px.green = clamp8(ys - 88 * cb - 183 * cr);
         px.blue = clamp8(ys + 454 * cb);
         px.last_of_pair = 1'b0;
         px.end_of_line = 1'b0;
         px.end_of_frame = 1'b0;
         return px;
      endfunction

      function void take_macropixel(req_word_type w);
         rsp_word_type px;
         int cb, cr, lim_w, lim_h;
         bit eol, eof;
         cb = int'(w.chroma_blue) - 128;
         cr = int'(w.chroma_red) - 128;
         lim_w = int'(width_reg);
         lim_h = int'(height_reg);
         if (lim_w > MAX_LINE_PIXELS) lim_w = MAX_LINE_PIXELS;
         if (lim_w < 2) lim_w = 2;
         if (lim_h > MAX_LINES) lim_h = MAX_LINES;
         if (lim_h < 1) lim_h = 1;
         eol = 2 * (int'(column_count) + 1) >= lim_w;
         eof = eol && (int'(row_count) + 1 >= lim_h);
         pixel_queue.push_back(convert(int'(w.luma_first), cb, cr));
         px = convert(int'(w.luma_second), cb, cr);
         px.last_of_pair = 1'b1;
         px.end_of_line = eol;
         px.end_of_frame = eof;
         pixel_queue.push_back(px);
         if (eol) begin
            column_count = '0;
            row_count = eof ? '0 : row_count + 1'b1;
         end else begin
            column_count = column_count + 1'b1;
         end
         words_in++;
      endfunction

      function void compare(string name, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      function void check_pixel(rsp_word_type got);
         rsp_word_type want;
         if (pixel_queue.size() == 0) begin
            errors++;
            $display("%0t: pixel %h arrived, expected none", $time, got);
            return;
         end
         want = pixel_queue.pop_front();
         pixels_checked++;
         compare("red", want.red, got.red);
         compare("green", want.green, got.green);
         compare("blue", want.blue, got.blue);
         compare("last_of_pair", 8'(want.last_of_pair), 8'(got.last_of_pair));
         compare("end_of_line", 8'(want.end_of_line), 8'(got.end_of_line));
         compare("end_of_frame", 8'(want.end_of_frame), 8'(got.end_of_frame));
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_word_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_word_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CFG_WIDTH-1:0] csr_wdata;

   rgb_predictor rgb_pred = new();
   int send_idle_pct;
   int recv_idle_pct;
   int hold_requests;
   int csr_writes;

   int phase_w[PHASES] = '{0, 5, 2, 4096, 8191, 7, 640, 1, 6, 4097, 12, 3};
   int phase_h[PHASES] = '{0, 2, 1, 4096, 8191, 3, 480, 5, 0, 2, 4097, 1};

   req_word_type corner_words[CORNERS] = '{
      {8'd0, 8'd0, 8'd0, 8'd0},
      {8'd255, 8'd255, 8'd255, 8'd255},
      {8'd0, 8'd128, 8'd255, 8'd128},
      {8'd255, 8'd0, 8'd0, 8'd255},
      {8'd0, 8'd255, 8'd255, 8'd0},
      {8'd128, 8'd128, 8'd128, 8'd128},
      {8'd16, 8'd128, 8'd235, 8'd128},
      {8'd255, 8'd0, 8'd255, 8'd0},
      {8'd0, 8'd255, 8'd0, 8'd255},
      {8'd235, 8'd16, 8'd16, 8'd240},
      {8'd1, 8'd127, 8'd254, 8'd129},
      {8'd170, 8'd85, 8'd85, 8'd170},
      {8'd85, 8'd170, 8'd170, 8'd85},
      {8'd128, 8'd0, 8'd128, 8'd0}
   };

   yuyv_to_rgb_converter uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) rgb_pred.take_macropixel(req_data);
         if (rsp_valid && rsp_ready) rgb_pred.check_pixel(rsp_data);
         if (csr_valid && csr_ready) begin
            rgb_pred.note_reg(csr_index, csr_wdata);
            csr_writes++;
         end
      end
   end

   // receiver: random back-pressure, plus long hold-offs on request
   initial begin
      int holds_done;
      int stall_left;
      holds_done = 0;
      stall_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_done) begin
            holds_done++;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(9))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'd128;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic req_word_type random_word();
      return {rand_byte(), rand_byte(), rand_byte(), rand_byte()};
   endfunction

   task automatic send_word(input req_word_type w);
      @(negedge clock);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic quiet_sender();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (rgb_pred.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic program_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                              input logic [CFG_WIDTH-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = CSR_FRAME_WIDTH;
      csr_wdata = '0;
      send_idle_pct = 27;
      recv_idle_pct = 50;
      hold_requests = 0;
      csr_writes = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < CORNERS; i++) send_word(corner_words[i]);
      quiet_sender();
      wait_drained();
      // spare indexes must leave the frame at 640 by 480
      program_reg(CSR_SPARE_2, 13'h1fff);
      program_reg(CSR_SPARE_3, 13'd2);
      for (int i = 0; i < 4; i++) send_word(random_word());
      quiet_sender();
      wait_drained();

      for (int p = 0; p < PHASES; p++) begin
         if (p < 4) begin
            send_idle_pct = 27;
            recv_idle_pct = 50;
         end else if (p < 8) begin
            send_idle_pct = 50;
            recv_idle_pct = 27;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         program_reg(CSR_FRAME_WIDTH, 13'(phase_w[p]));
         program_reg(CSR_FRAME_HEIGHT, 13'(phase_h[p]));
         if (p % 2 == 1)
            program_reg((p % 4 == 1) ? CSR_SPARE_2 : CSR_SPARE_3, 13'($urandom_range(8191)));
         n = $urandom_range(90, 118);
         for (int i = 0; i < n; i++) begin
            send_word(random_word());
            if (i == n / 2) begin
               if (p == 2 || p == 6 || p == 10) hold_requests++;
               if (p == 5 || p == 9) begin
                  quiet_sender();
                  while (rgb_pred.pending() != 0) @(negedge clock);
               end
            end
         end
         quiet_sender();
         wait_drained();
      end

      $display("Converted %0d macropixels into %0d checked pixels with %0d register writes,",
               rgb_pred.words_in, rgb_pred.pixels_checked, csr_writes);
      $display("across %0d frame shapes incl. clamped sizes, hold-offs and sender pauses.",
               PHASES + 1);
      if (rgb_pred.errors == 0 && rgb_pred.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #(LIMIT_NS);
      $display("FAIL");
      $finish;
   end

endmodule

FILE: files.f
+incdir+hdl
hdl/yuyv_pkg.sv
hdl/yuyv_front.sv
hdl/yuyv_queue.sv
hdl/yuyv_back.sv
hdl/yuyv_to_rgb_converter.sv
bench/tb_yuyv_to_rgb_converter.sv
